/* hdl/mlcs_pkg.sv */
// Shared types and constants for the MCU luma split and chroma subsampler.
// Holds the request/response payload structs, register indexes and mode codes.
// No dependencies.
package mlcs_pkg;

   // Default luma block edge in pixels
   localparam int BLOCK_SIZE_DEF = 8;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CHROMA_MODE = 2'd0,
      CSR_MCU_WIDE    = 2'd1,
      CSR_MCU_TALL    = 2'd2
   } csr_addr_type;

   // Chroma subsampling modes; the spare code behaves as full resolution
   typedef enum logic [1:0] {
      CHROMA_FULL = 2'd0,
      CHROMA_H2   = 2'd1,
      CHROMA_HV2  = 2'd2
   } chroma_mode_type;

   // One pixel of the MCU
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] blue_diff;
      logic [7:0] red_diff;
   } req_type;

   // One result per pixel
   typedef struct packed {
      logic [1:0] luma_block;
      logic [2:0] luma_row;
      logic [2:0] luma_col;
      logic [7:0] luma_value;
      logic       chroma_valid;
      logic [2:0] chroma_row;
      logic [2:0] chroma_col;
      logic [7:0] cb_value;
      logic [7:0] cr_value;
      logic       mcu_last;
   } rsp_type;

endpackage

/* hdl/mlcs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first behaviour on a same-address collision. No dependencies.
module mlcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mcu_luma_split_chroma_subsample.sv */
// Top level of the MCU luma split and chroma subsampler.
// Depends on mlcs_pkg (types, codes) and mlcs_ram (chroma line store).
//
// Usage:
//   req_* : one pixel (Y, Cb, Cr) per request, MCU pixels in raster order.
//   rsp_* : one result per pixel: luma block/row/column and, when a
//           subsampled chroma sample completes, its position and Cb/Cr sums.
//   csr_* : write-only registers (chroma mode, MCU width, MCU height); write
//           them only while no request is in flight.
// Timing:
//   A request accepted into the working stage registers moves on to the
//   output register when the response side is not stalled. One request
//   per cycle is sustained while rsp_ready is high; the line store is
//   read as the request is accepted and written as the request leaves the
//   working stage, with a bypass when both touch the same entry.
// Reset:
//   Synchronous, active high. Position counters, partial sums, valid flags
//   and configuration registers clear; the line store is not cleared and
//   is always written on an even row before an odd row reads it.
// Back-pressure:
//   With rsp_ready low the output register holds, then the working stage
//   holds, then req_ready drops. Nothing is lost or repeated.
module mcu_luma_split_chroma_subsample #(
   parameter int BLOCK_SIZE = mlcs_pkg::BLOCK_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mlcs_pkg::req_type               req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mlcs_pkg::rsp_type               rsp_data,
   // configuration port
   input  logic                            csr_we,
   input  logic [mlcs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mlcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(2 * BLOCK_SIZE);   // pixel counter width
   localparam int AW = $clog2(BLOCK_SIZE);       // line store address width
   localparam logic [CW:0] SPAN_ONE = (CW + 1)'(BLOCK_SIZE);
   localparam logic [CW:0] SPAN_TWO = (CW + 1)'(2 * BLOCK_SIZE);
   localparam logic [CW-1:0] HALF = CW'(BLOCK_SIZE);

   // Configuration registers
   logic [1:0] mode_ff;
   logic       wide_ff;
   logic       tall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mlcs_pkg::CHROMA_FULL;
         wide_ff <= 1'b0;
         tall_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            mlcs_pkg::CSR_CHROMA_MODE: mode_ff <= csr_wdata;
            mlcs_pkg::CSR_MCU_WIDE:    wide_ff <= csr_wdata[0];
            mlcs_pkg::CSR_MCU_TALL:    tall_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake and stage control
   logic s1_vld_ff;
   logic out_vld_ff;
   logic s1_fire;
   logic req_fire;

   assign s1_fire   = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Stage 0: pixel position counters
   logic [CW-1:0] pixel_row_ff, pixel_row_in;
   logic [CW-1:0] pixel_col_ff, pixel_col_in;
   logic [CW:0]   width, height, row_inc, col_inc;
   logic          col_end, row_end, last_pix;

   always_comb begin
      width   = wide_ff ? SPAN_TWO : SPAN_ONE;
      height  = tall_ff ? SPAN_TWO : SPAN_ONE;
      row_inc = {1'b0, pixel_row_ff} + 1'b1;
      col_inc = {1'b0, pixel_col_ff} + 1'b1;
      col_end = col_inc >= width;
      row_end = row_inc >= height;
      last_pix = col_end && row_end;
      if (col_end) begin
         pixel_col_in = '0;
         pixel_row_in = row_end ? '0 : row_inc[CW-1:0];
      end else begin
         pixel_col_in = col_inc[CW-1:0];
         pixel_row_in = pixel_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_row_ff <= '0;
         pixel_col_ff <= '0;
      end else if (req_fire) begin
         pixel_row_ff <= pixel_row_in;
         pixel_col_ff <= pixel_col_in;
      end
   end

   // Stage 1 registers: request, its position, last flag
   mlcs_pkg::req_type s1_req_ff;
   logic [CW-1:0]     s1_row_ff;
   logic [CW-1:0]     s1_col_ff;
   logic              s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff  <= req_data;
         s1_row_ff  <= pixel_row_ff;
         s1_col_ff  <= pixel_col_ff;
         s1_last_ff <= last_pix;
      end
   end

   // Line store of even-row partial sums, {cb, cr}
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   assign ram_waddr = s1_col_ff[CW-1:1];
   assign ram_raddr = pixel_col_ff[CW-1:1];

   mlcs_ram #(
      .WIDTH (16),
      .DEPTH (BLOCK_SIZE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Bypass: a read issued in the same cycle as a write to that entry
   logic        fwd_ff;
   logic [15:0] fwd_data_ff;
   logic [15:0] line_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (req_fire) begin
         fwd_ff <= ram_we && (ram_waddr == ram_raddr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         fwd_data_ff <= ram_wdata;
      end
   end

   assign line_sum = fwd_ff ? fwd_data_ff : ram_rdata;

   // Stage 1: chroma accumulation and result assembly
   logic [7:0]        held_cb_ff, held_cb_in;
   logic [7:0]        held_cr_ff, held_cr_in;
   logic              held_we;
   logic [7:0]        cb_half, cr_half, cb_qtr, cr_qtr;
   logic [CW-1:0]     row_rem, col_rem;
   mlcs_pkg::rsp_type rsp_in;

   always_comb begin
      cb_half = s1_req_ff.blue_diff >> 1;
      cr_half = s1_req_ff.red_diff >> 1;
      cb_qtr  = s1_req_ff.blue_diff >> 2;
      cr_qtr  = s1_req_ff.red_diff >> 2;
      row_rem = (s1_row_ff >= HALF) ? s1_row_ff - HALF : s1_row_ff;
      col_rem = (s1_col_ff >= HALF) ? s1_col_ff - HALF : s1_col_ff;

      held_we    = 1'b0;
      held_cb_in = held_cb_ff;
      held_cr_in = held_cr_ff;
      ram_we     = 1'b0;
      ram_wdata  = {held_cb_ff + cb_qtr, held_cr_ff + cr_qtr};

      rsp_in              = '0;
      rsp_in.luma_block   = {s1_row_ff >= HALF, s1_col_ff >= HALF};
      rsp_in.luma_row     = 3'(row_rem);
      rsp_in.luma_col     = 3'(col_rem);
      rsp_in.luma_value   = s1_req_ff.luma;
      rsp_in.mcu_last     = s1_last_ff;

      case (mode_ff)
         mlcs_pkg::CHROMA_H2: begin
            if (!s1_col_ff[0]) begin
               held_we    = 1'b1;
               held_cb_in = cb_half;
               held_cr_in = cr_half;
            end else begin
               rsp_in.chroma_valid = 1'b1;
               rsp_in.chroma_row   = 3'(s1_row_ff);
               rsp_in.chroma_col   = 3'(s1_col_ff >> 1);
               rsp_in.cb_value     = held_cb_ff + cb_half;
               rsp_in.cr_value     = held_cr_ff + cr_half;
            end
         end
         mlcs_pkg::CHROMA_HV2: begin
            if (!s1_row_ff[0]) begin
               // even row: pair sums go to the line store
               if (!s1_col_ff[0]) begin
                  held_we    = 1'b1;
                  held_cb_in = cb_qtr;
                  held_cr_in = cr_qtr;
               end else begin
                  ram_we = s1_fire;
               end
            end else if (!s1_col_ff[0]) begin
               // odd row, even column: pick up the line sum
               held_we    = 1'b1;
               held_cb_in = line_sum[15:8] + cb_qtr;
               held_cr_in = line_sum[7:0] + cr_qtr;
            end else begin
               rsp_in.chroma_valid = 1'b1;
               rsp_in.chroma_row   = 3'(s1_row_ff >> 1);
               rsp_in.chroma_col   = 3'(s1_col_ff >> 1);
               rsp_in.cb_value     = held_cb_ff + cb_qtr;
               rsp_in.cr_value     = held_cr_ff + cr_qtr;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cb_ff <= '0;
         held_cr_ff <= '0;
      end else if (s1_fire && held_we) begin
         held_cb_ff <= held_cb_in;
         held_cr_ff <= held_cr_in;
      end
   end

   // Output register
   mlcs_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         out_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_counter_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pixel_col_ff} < SPAN_TWO) && ({1'b0, pixel_row_ff} < SPAN_TWO))
      else $error("pixel counter beyond MCU bound");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      req_fire && last_pix |=> (pixel_row_ff == '0) && (pixel_col_ff == '0))
      else $error("counters did not wrap after last pixel");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_vld_ff && out_vld_ff && !rsp_ready)
      else $error("request refused without a full pipeline");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_fire |=> s1_vld_ff && $stable(s1_row_ff) && $stable(s1_col_ff))
      else $error("working stage lost its request while stalled");

endmodule
